@@ rtl/core/dpcb_pkg.sv @@
// Package for the debounced pulse counter bank: item types, codes, state types and constants
`default_nettype none

package dpcb_pkg;

	// bank size and pin word
	localparam int CHANNELS_DEFAULT = 10;
	localparam int PIN_BITS         = 10;
	localparam int PIN_IW           = 4;
	localparam int CH_BITS          = 4;
	localparam int CH_CMP_W         = 7;

	// configuration registers
	localparam logic [7:0] DELAY_RESET    = 8'd2;
	localparam logic       CFG_HIGH_DELAY = 1'b0;
	localparam logic       CFG_LOW_DELAY  = 1'b1;

	// operation codes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_RESET = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]          operation;
		logic [PIN_BITS-1:0] pin_levels;
		logic [CH_BITS-1:0]  channel;
	} in_word_t;

	typedef struct packed {
		logic [CH_BITS-1:0] read_channel;
		logic [15:0]        short_count;
		logic [31:0]        total_count;
		logic               raw_level;
	} out_word_t;

	// one memory entry per channel
	typedef struct packed {
		logic        qualified_low;
		logic [7:0]  high_run;
		logic [7:0]  low_run;
		logic        last_raw;
		logic [15:0] short_pulses;
		logic [31:0] total_pulses;
	} chan_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FETCH,
		S_FINISH
	} seq_state_t;

endpackage

`default_nettype wire

@@ rtl/core/debounced_pulse_counter_bank.sv @@
// Debounced pulse counter bank: sequencer, per-channel state memory and result register
//
// A bank of CHANNELS debounced inputs, each counting qualified high-to-low pulses into a
// clearable 16-bit count and a 32-bit total. The state of every channel lives in one
// memory entry. A tick word walks the channels one per cycle through a read, update and
// write-back, holding off the input until done; reset-channel stays idle, clear and read
// pass fetch and finish states (read, then modify or report). The read result sits in an
// output register, so the next word can be taken while it waits. Pins above bit 9 sample as
// low. The user must write delays on the configuration port only while the bank is idle
// (unenforced); register 0 is the high delay, register 1 the low, both 2 after reset.
`default_nettype none

module debounced_pulse_counter_bank #(
	parameter int CHANNELS = dpcb_pkg::CHANNELS_DEFAULT
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire dpcb_pkg::in_word_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output dpcb_pkg::out_word_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic                cfg_index,
	input  wire logic [7:0]          cfg_data
);

	import dpcb_pkg::*;

	localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW = $bits(chan_state_t);

	seq_state_t state_q, state_d;

	logic [7:0]          high_delay_q, low_delay_q;
	logic [1:0]          op_q;
	logic [PIN_BITS-1:0] pins_q;
	logic [CH_BITS-1:0]  ch_q;
	logic [AW-1:0]       idx_q;
	logic [CHANNELS-1:0] valid_q;

	logic                scan_s1;
	logic [AW-1:0]       addr_s1;
	logic                level_s1;

	logic                out_valid_q;
	out_word_t           out_data_q;

	logic                in_acc;
	logic                out_load;
	logic                ch_ok, ch_q_ok;
	logic [AW-1:0]       ch_addr, ch_q_addr;
	logic                last_idx;

	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [SW-1:0]       rd_data;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	chan_state_t         wr_data;

	logic [AW-1:0]       data_addr;
	chan_state_t         ent;
	chan_state_t         scan_next;
	chan_state_t         clr_next;

	// raw level of a channel, pins above the pin word read low
	function automatic logic pin_level(input logic [PIN_BITS-1:0] pins,
			input logic [AW-1:0] idx);
		logic [CH_CMP_W-1:0] ix;
		ix = CH_CMP_W'(idx);
		if (ix < CH_CMP_W'(PIN_BITS)) begin
			pin_level = pins[ix[PIN_IW-1:0]];
		end else begin
			pin_level = 1'b0;
		end
	endfunction

	function automatic logic [7:0] inc_sat(input logic [7:0] v);
		inc_sat = (v == 8'hff) ? v : v + 8'd1;
	endfunction

	// handshakes
	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_load  = (state_q == S_FINISH) && (op_q == OP_READ) &&
		(!out_valid_q || out_ready);

	// channel decode for the incoming word and the held word
	assign ch_ok     = CH_CMP_W'(in_data.channel) < CH_CMP_W'(CHANNELS);
	assign ch_addr   = AW'(CH_CMP_W'(in_data.channel));
	assign ch_q_ok   = CH_CMP_W'(ch_q) < CH_CMP_W'(CHANNELS);
	assign ch_q_addr = AW'(CH_CMP_W'(ch_q));
	assign last_idx  = (idx_q == AW'(CHANNELS - 1));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					case (in_data.operation)
						OP_TICK:  state_d = S_SCAN;
						OP_CLEAR: state_d = ch_ok ? S_FETCH : S_IDLE;
						OP_READ:  state_d = S_FETCH;
						default:  state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				if (last_idx) begin
					state_d = S_IDLE;
				end
			end
			S_FETCH:  state_d = S_FINISH;
			S_FINISH: begin
				if (op_q != OP_READ || out_load) begin
					state_d = S_IDLE;
				end
			end
			default:  state_d = S_IDLE;
		endcase
	end

	// memory read port
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = ch_q_addr;
		case (state_q)
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
			end
			S_FETCH: begin
				rd_en   = 1'b1;
				rd_addr = ch_q_addr;
			end
			default: begin
				rd_en   = 1'b0;
				rd_addr = ch_q_addr;
			end
		endcase
	end

	// entry as read, never-written or reset entries read as zero
	assign data_addr = scan_s1 ? addr_s1 : ch_q_addr;
	assign ent       = valid_q[data_addr] ? chan_state_t'(rd_data) : '0;

	// debounce and count update of one channel
	always_comb begin
		scan_next = ent;
		if (!level_s1) begin
			scan_next.last_raw = 1'b0;
			scan_next.high_run = 8'd0;
			scan_next.low_run  = inc_sat(ent.low_run);
		end else begin
			scan_next.last_raw = 1'b1;
			scan_next.high_run = inc_sat(ent.high_run);
			scan_next.low_run  = 8'd0;
		end
		if (scan_next.high_run >= high_delay_q) begin
			scan_next.qualified_low = 1'b0;
			scan_next.high_run      = 8'd0;
			scan_next.low_run       = 8'd0;
		end
		if (scan_next.low_run >= low_delay_q) begin
			if (!scan_next.qualified_low) begin
				scan_next.total_pulses = scan_next.total_pulses + 32'd1;
				scan_next.short_pulses = scan_next.short_pulses + 16'd1;
			end
			scan_next.qualified_low = 1'b1;
			scan_next.high_run      = 8'd0;
			scan_next.low_run       = 8'd0;
		end
	end

	// short count clear
	always_comb begin
		clr_next              = ent;
		clr_next.short_pulses = 16'd0;
	end

	// memory write port
	assign wr_en   = scan_s1 || ((state_q == S_FINISH) && (op_q == OP_CLEAR));
	assign wr_addr = scan_s1 ? addr_s1 : ch_q_addr;
	assign wr_data = scan_s1 ? scan_next : clr_next;

	dpcb_ram #(
		.WIDTH (SW),
		.DEPTH (CHANNELS)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (SW'(wr_data)),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// sequencer state and channel walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			scan_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			scan_s1 <= (state_q == S_SCAN);
			if (in_acc) begin
				idx_q <= '0;
			end else if (state_q == S_SCAN) begin
				idx_q <= idx_q + AW'(1);
			end
		end
	end

	// held word and scan stage payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q   <= in_data.operation;
			pins_q <= in_data.pin_levels;
			ch_q   <= in_data.channel;
		end
		addr_s1  <= idx_q;
		level_s1 <= pin_level(pins_q, idx_q);
	end

	// entry valid bits, a channel reset wins over a same-edge write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (in_acc && (in_data.operation == OP_RESET) && ch_ok) begin
				valid_q[ch_addr] <= 1'b0;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_delay_q <= DELAY_RESET;
			low_delay_q  <= DELAY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_HIGH_DELAY: high_delay_q <= cfg_data;
				CFG_LOW_DELAY:  low_delay_q  <= cfg_data;
				default:        high_delay_q <= high_delay_q;
			endcase
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q.read_channel <= ch_q;
			out_data_q.short_count  <= ch_q_ok ? ent.short_pulses : 16'd0;
			out_data_q.total_count  <= ch_q_ok ? ent.total_pulses : 32'd0;
			out_data_q.raw_level    <= ch_q_ok ? ent.last_raw : 1'b0;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/dpcb_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port
`default_nettype none

module dpcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ verif/tb_debounced_pulse_counter_bank.sv @@
// Testbench for the debounced pulse counter bank: scoreboard class, word drivers and checks
`timescale 1ns / 100ps

module tb_debounced_pulse_counter_bank;
	import dpcb_pkg::*;

	localparam int NCH        = CHANNELS_DEFAULT;
	localparam int CH_MAX     = (1 << CH_BITS) - 1;
	localparam int SETTLE     = 2 * (NCH + 1) + 10;
	localparam int ZERO_TICKS = 20;

	// tracks every channel of the bank and the reads still owed by it
	class pulse_count_tracker;
		bit [7:0]   hi_need;
		bit [7:0]   lo_need;
		bit         is_low    [NCH];
		bit [7:0]   hi_len    [NCH];
		bit [7:0]   lo_len    [NCH];
		bit         raw_seen  [NCH];
		bit [15:0]  short_cnt [NCH];
		bit [31:0]  total_cnt [NCH];
		out_word_t  pending_reads [$];
		int         errors;
		int         checked;

		function new();
			int n;
			for (n = 0; n < NCH; n++)
				wipe_channel(n);
			hi_need = DELAY_RESET;
			lo_need = DELAY_RESET;
			errors  = 0;
			checked = 0;
		endfunction

		function void wipe_channel(int n);
			is_low[n]    = 1'b0;
			hi_len[n]    = '0;
			lo_len[n]    = '0;
			raw_seen[n]  = 1'b0;
			short_cnt[n] = '0;
			total_cnt[n] = '0;
		endfunction

		function void set_delay(logic idx, logic [7:0] value);
			if (idx == CFG_HIGH_DELAY)
				hi_need = value;
			else
				lo_need = value;
		endfunction

		function void note_fail(string msg);
			errors++;
			if (errors <= 10)
				$display("[%0t] %s", $time, msg);
		endfunction

		// note an accepted input word and work out what it owes
		function void apply_word(in_word_t w);
			out_word_t want;
			int        n;
			bit        lvl;
			case (w.operation)
				OP_TICK: begin
					for (n = 0; n < NCH; n++) begin
						lvl = (n < PIN_BITS) ? w.pin_levels[n] : 1'b0;
						raw_seen[n] = lvl;
						// grow the run of the sampled level, drop the other
						if (lvl) begin
							if (hi_len[n] != 8'hFF)
								hi_len[n] = hi_len[n] + 8'd1;
							lo_len[n] = '0;
						end else begin
							if (lo_len[n] != 8'hFF)
								lo_len[n] = lo_len[n] + 8'd1;
							hi_len[n] = '0;
						end
						// high qualification is looked at first
						if (hi_len[n] >= hi_need) begin
							is_low[n] = 1'b0;
							hi_len[n] = '0;
							lo_len[n] = '0;
						end
						// falling edge of the qualified level counts a pulse
						if (lo_len[n] >= lo_need) begin
							if (!is_low[n]) begin
								short_cnt[n] = short_cnt[n] + 16'd1;
								total_cnt[n] = total_cnt[n] + 32'd1;
							end
							is_low[n] = 1'b1;
							hi_len[n] = '0;
							lo_len[n] = '0;
						end
					end
				end
				OP_RESET: begin
					if (w.channel < NCH)
						wipe_channel(w.channel);
				end
				OP_CLEAR: begin
					if (w.channel < NCH)
						short_cnt[w.channel] = '0;
				end
				default: begin
					want = '0;
					want.read_channel = w.channel;
					if (w.channel < NCH) begin
						want.short_count = short_cnt[w.channel];
						want.total_count = total_cnt[w.channel];
						want.raw_level   = raw_seen[w.channel];
					end
					pending_reads.push_back(want);
				end
			endcase
		endfunction

		// compare one read result with the oldest one owed
		function void check_read(out_word_t got);
			out_word_t want;
			if (pending_reads.size() == 0) begin
				note_fail($sformatf("unexpected read result: ch %0d short %0d total %0d raw %0b",
					got.read_channel, got.short_count, got.total_count, got.raw_level));
				return;
			end
			want = pending_reads.pop_front();
			checked++;
			if (got.read_channel !== want.read_channel || got.short_count !== want.short_count ||
			    got.total_count !== want.total_count || got.raw_level !== want.raw_level)
				note_fail($sformatf({"read mismatch: want ch %0d short %0d total %0d raw %0b, ",
					"got ch %0d short %0d total %0d raw %0b"},
					want.read_channel, want.short_count, want.total_count, want.raw_level,
					got.read_channel, got.short_count, got.total_count, got.raw_level));
		endfunction
	endclass

	typedef enum int {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	in_word_t           in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	out_word_t          out_data;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = CFG_HIGH_DELAY;
	logic [7:0]         cfg_data  = '0;

	pulse_count_tracker tracker;
	rx_mode_t           rx_mode    = RX_OPEN;
	int                 rx_left    = 0;
	int                 words_in   = 0;
	int                 settings   = 1;
	logic [PIN_BITS-1:0] pin_now   = '0;
	int                 pin_hold [PIN_BITS];
	int                 hold_lo    = 1;
	int                 hold_hi    = 4;

	debounced_pulse_counter_bank u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// watchdog
	initial begin
		#(64'd40_000_000);
		$display("Regression FAIL");
		$finish;
	end

	// receiver stalls, switching at random among four habits
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			rx_left <= $urandom_range(16, 96);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_OPEN:     out_ready <= 1'b1;
			RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
			default:     out_ready <= (rx_left % 5 == 0);
		endcase
	end

	// observe handshakes on all three channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				tracker.check_read(out_data);
			if (in_valid && in_ready) begin
				tracker.apply_word(in_data);
				words_in++;
			end
			if (cfg_valid && cfg_ready)
				tracker.set_delay(cfg_index, cfg_data);
		end
	end

	function automatic in_word_t mk_word(logic [1:0] op, logic [PIN_BITS-1:0] pins,
	                                     logic [CH_BITS-1:0] ch);
		in_word_t w;
		w.operation  = op;
		w.pin_levels = pins;
		w.channel    = ch;
		return w;
	endfunction

	// pin levels held for runs around the current delays, with some noise
	function automatic logic [PIN_BITS-1:0] next_pins();
		int n;
		if ($urandom_range(0, 9) == 0)
			return PIN_BITS'($urandom);
		for (n = 0; n < PIN_BITS; n++) begin
			if (pin_hold[n] <= 0) begin
				pin_now[n]  = ~pin_now[n];
				pin_hold[n] = $urandom_range(hold_lo, hold_hi);
			end else begin
				pin_hold[n]--;
			end
		end
		return pin_now;
	endfunction

	function automatic in_word_t random_word();
		in_word_t w;
		int       pick;
		pick         = $urandom_range(0, 99);
		w.pin_levels = PIN_BITS'($urandom);
		if ($urandom_range(0, 7) == 0)
			w.channel = CH_BITS'($urandom_range(NCH, CH_MAX));
		else
			w.channel = CH_BITS'($urandom_range(0, NCH - 1));
		if (pick < 68) begin
			w.operation  = OP_TICK;
			w.pin_levels = next_pins();
		end else if (pick < 82) begin
			w.operation = OP_READ;
		end else if (pick < 92) begin
			w.operation = OP_CLEAR;
		end else begin
			w.operation = OP_RESET;
		end
		return w;
	endfunction

	// present one word and hold it until taken; valid stays high afterwards
	task automatic send_word(input in_word_t w);
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pause_sender(input int cycles);
		if (cycles > 0) begin
			in_valid <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	// hold off until every read has come back and the bank has gone quiet
	task automatic drain_bank();
		in_valid <= 1'b0;
		while (tracker.pending_reads.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both delay registers, valid kept high across the pair
	task automatic set_delays(input logic [7:0] hi, input logic [7:0] lo);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_HIGH_DELAY;
		cfg_data  <= hi;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_LOW_DELAY;
		cfg_data  <= lo;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// random words in bursts with random gaps
	task automatic run_items(input int count);
		int burst;
		int i;
		int dmax;
		dmax    = (tracker.hi_need > tracker.lo_need) ? tracker.hi_need : tracker.lo_need;
		hold_lo = 1 + dmax / 2;
		hold_hi = 2 * dmax + 3;
		burst   = 0;
		for (i = 0; i < count; i++) begin
			if (burst == 0) begin
				pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
				burst = $urandom_range(1, 16);
			end
			send_word(random_word());
			burst--;
		end
	endtask

	// main sequence
	initial begin
		int n;
		tracker = new();
		for (n = 0; n < PIN_BITS; n++)
			pin_hold[n] = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed words at the reset delays
		send_word(mk_word(OP_READ, '0, 4'd0));
		send_word(mk_word(OP_READ, '1, CH_BITS'(CH_MAX)));
		send_word(mk_word(OP_TICK, '1, 4'd0));
		send_word(mk_word(OP_TICK, '1, CH_BITS'(CH_MAX)));
		send_word(mk_word(OP_TICK, '0, 4'd0));
		send_word(mk_word(OP_TICK, '0, 4'd0));
		send_word(mk_word(OP_TICK, 10'h2AA, 4'd0));
		send_word(mk_word(OP_TICK, 10'h2AA, 4'd0));
		send_word(mk_word(OP_TICK, 10'h155, 4'd0));
		send_word(mk_word(OP_TICK, 10'h155, 4'd0));
		send_word(mk_word(OP_READ, '0, 4'd1));
		send_word(mk_word(OP_READ, '0, CH_BITS'(NCH - 1)));
		send_word(mk_word(OP_CLEAR, '0, 4'd1));
		send_word(mk_word(OP_READ, '0, 4'd1));
		send_word(mk_word(OP_RESET, '0, CH_BITS'(NCH - 1)));
		send_word(mk_word(OP_READ, '0, CH_BITS'(NCH - 1)));
		send_word(mk_word(OP_RESET, '1, 4'd12));
		send_word(mk_word(OP_CLEAR, '1, CH_BITS'(CH_MAX)));
		send_word(mk_word(OP_READ, '0, CH_BITS'(NCH)));
		send_word(mk_word(OP_TICK, '1, 4'd0));
		send_word(mk_word(OP_READ, '0, 4'd8));
		send_word(mk_word(OP_READ, '0, 4'd3));

		// random words at the reset delays
		run_items(120);
		drain_bank();

		// longest delays
		set_delays(8'd255, 8'd255);
		run_items(200);
		drain_bank();

		// zero delays: every tick counts a pulse on every channel
		set_delays(8'd0, 8'd0);
		run_items(50);
		for (n = 0; n < NCH; n++)
			send_word(mk_word(OP_CLEAR, PIN_BITS'($urandom), CH_BITS'(n)));
		// a short run of ticks back to back after the clears
		for (n = 0; n < ZERO_TICKS; n++)
			send_word(mk_word(OP_TICK, PIN_BITS'($urandom), CH_BITS'($urandom)));
		for (n = 0; n < NCH; n++)
			send_word(mk_word(OP_READ, PIN_BITS'($urandom), CH_BITS'(n)));
		drain_bank();

		// delays of one
		set_delays(8'd1, 8'd1);
		run_items(60);
		drain_bank();

		// lopsided extremes
		set_delays(8'd1, 8'd255);
		run_items(80);
		drain_bank();

		// random moderate delays
		repeat (2) begin
			set_delays(8'($urandom_range(2, 24)), 8'($urandom_range(2, 24)));
			run_items(150);
			drain_bank();
		end

		if (tracker.pending_reads.size() != 0)
			tracker.note_fail($sformatf("%0d reads never answered",
				tracker.pending_reads.size()));
		$display("Sent %0d words across %0d delay settings, zero, one and 255 included",
			words_in, settings);
		$display("%0d reads checked, %0d mismatches", tracker.checked, tracker.errors);
		if (tracker.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
